FILE: rtl/sensor_response_frame_checker_unit_defines.svh
// Assertion macros used by the frame checker assertion module.
`ifndef SENSOR_RESPONSE_FRAME_CHECKER_UNIT_DEFINES_SVH
`define SENSOR_RESPONSE_FRAME_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SRFC_ASSERT_IMP(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
    else $error("frame checker assertion failed");

// Next-cycle implication, disabled during reset.
`define SRFC_ASSERT_NXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
    else $error("frame checker assertion failed");

`endif

FILE: rtl/srfc_pkg.sv
// Constants, types and helpers of the sensor response frame checker.
package srfc_pkg;

  localparam int HEAD_BYTES = 8;
  localparam int HEAD_IDX_W = $clog2(HEAD_BYTES);
  localparam int CNT_W      = 6;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic [CNT_W-1:0] MIN_BYTES = CNT_W'(3);

  localparam logic [7:0] HEADER_CODE = 8'h16;
  localparam logic [7:0] ACK_MAX_LEN = 8'h04;

  localparam logic [7:0] CMD_READ_CO2  = 8'h01;
  localparam logic [7:0] CMD_ZERO_CAL  = 8'h03;
  localparam logic [7:0] CMD_ABC       = 8'h0F;
  localparam logic [7:0] CMD_SET_ABC   = 8'h10;
  localparam logic [7:0] CMD_SPAN_CAL  = 8'h11;
  localparam logic [7:0] CMD_VERSION   = 8'h1E;
  localparam logic [7:0] CMD_SERIAL    = 8'h1F;
  localparam logic [7:0] CMD_MEAS_CFG  = 8'h50;
  localparam logic [7:0] CMD_WORK_MODE = 8'h51;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_SHORT      = 2'd1,
    ST_BAD_HEADER = 2'd2,
    ST_BAD_SUM    = 2'd3
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  command;
    logic        known_command;
    logic [15:0] co2_ppm;
    logic [7:0]  abc_enable;
    logic [7:0]  abc_period;
    logic [15:0] abc_base_ppm;
    logic [15:0] meas_period;
    logic [7:0]  smooth_count;
    logic [7:0]  work_mode;
    logic        is_set_ack;
  } result_t;

  function automatic logic is_known(input logic [7:0] c);
    return (c == CMD_READ_CO2) || (c == CMD_ZERO_CAL) || (c == CMD_ABC) ||
           (c == CMD_SET_ABC) || (c == CMD_SPAN_CAL) || (c == CMD_VERSION) ||
           (c == CMD_SERIAL) || (c == CMD_MEAS_CFG) || (c == CMD_WORK_MODE);
  endfunction

endpackage

FILE: rtl/srfc_if.sv
// Valid/ready channel interfaces for received bytes and frame results.
interface srfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, rx_byte, frame_end, input ready);
  modport sink   (input valid, rx_byte, frame_end, output ready);
endinterface

interface srfc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  command;
  logic        known_command;
  logic [15:0] co2_ppm;
  logic [7:0]  abc_enable;
  logic [7:0]  abc_period;
  logic [15:0] abc_base_ppm;
  logic [15:0] meas_period;
  logic [7:0]  smooth_count;
  logic [7:0]  work_mode;
  logic        is_set_ack;

  modport source (output valid, status, command, known_command, co2_ppm, abc_enable,
                  abc_period, abc_base_ppm, meas_period, smooth_count, work_mode,
                  is_set_ack, input ready);
  modport sink   (input valid, status, command, known_command, co2_ppm, abc_enable,
                  abc_period, abc_base_ppm, meas_period, smooth_count, work_mode,
                  is_set_ack, output ready);
endinterface

FILE: rtl/sensor_response_frame_checker_unit.sv
// Frame checker top: byte count, running sum, head store and result decode.
// Throughput: one byte word per cycle; the result word is valid in the cycle after the last byte is taken.
// The input is refused only while a result word waits and the sink is not ready.
// Frame state (count, sum, stored head bytes) and the output valid clear on reset;
// the frame state clears again after every frame end.
module sensor_response_frame_checker_unit
  import srfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  srfc_in_if.sink    in_ch,
  srfc_out_if.source out_ch
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       head_r   [HEAD_BYTES];
  logic [7:0]       head_nxt [HEAD_BYTES];
  result_t          res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             in_fire, out_fire, last_fire;
  status_t          st;
  logic [7:0]       cmd;
  logic             ack;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_valid_r && out_ch.ready;
  assign last_fire   = in_fire && in_ch.frame_end;

  always_comb begin
    head_nxt = head_r;
    if (count_r < CNT_W'(HEAD_BYTES)) begin
      head_nxt[count_r[HEAD_IDX_W-1:0]] = in_ch.rx_byte;
    end
    count_nxt = (count_r < COUNT_MAX) ? count_r + 1'b1 : count_r;
    sum_nxt   = sum_r + in_ch.rx_byte;
  end

  always_comb begin
    cmd = head_nxt[2];
    ack = head_nxt[1] <= ACK_MAX_LEN;
    if (count_nxt < MIN_BYTES) begin
      st = ST_SHORT;
    end else if (head_nxt[0] != HEADER_CODE) begin
      st = ST_BAD_HEADER;
    end else if (sum_nxt != 8'h00) begin
      st = ST_BAD_SUM;
    end else begin
      st = ST_OK;
    end
    res_nxt               = '0;
    res_nxt.status        = st;
    res_nxt.command       = cmd;
    res_nxt.known_command = is_known(cmd);
    if (st == ST_OK) begin
      case (cmd)
        CMD_READ_CO2: begin
          res_nxt.co2_ppm = {head_nxt[3], head_nxt[4]};
        end
        CMD_ABC: begin
          res_nxt.abc_enable   = head_nxt[4];
          res_nxt.abc_period   = head_nxt[5];
          res_nxt.abc_base_ppm = {head_nxt[6], head_nxt[7]};
        end
        CMD_MEAS_CFG: begin
          if (ack) begin
            res_nxt.is_set_ack = 1'b1;
          end else begin
            res_nxt.meas_period  = {head_nxt[3], head_nxt[4]};
            res_nxt.smooth_count = head_nxt[5];
          end
        end
        CMD_WORK_MODE: begin
          if (ack) begin
            res_nxt.is_set_ack = 1'b1;
          end else begin
            res_nxt.work_mode = head_nxt[3];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (last_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < HEAD_BYTES; i++) begin
        head_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (last_fire) begin
        count_r <= '0;
        sum_r   <= '0;
        for (int i = 0; i < HEAD_BYTES; i++) begin
          head_r[i] <= '0;
        end
      end else if (in_fire) begin
        count_r <= count_nxt;
        sum_r   <= sum_nxt;
        head_r  <= head_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (last_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = res_r.status;
  assign out_ch.command       = res_r.command;
  assign out_ch.known_command = res_r.known_command;
  assign out_ch.co2_ppm       = res_r.co2_ppm;
  assign out_ch.abc_enable    = res_r.abc_enable;
  assign out_ch.abc_period    = res_r.abc_period;
  assign out_ch.abc_base_ppm  = res_r.abc_base_ppm;
  assign out_ch.meas_period   = res_r.meas_period;
  assign out_ch.smooth_count  = res_r.smooth_count;
  assign out_ch.work_mode     = res_r.work_mode;
  assign out_ch.is_set_ack    = res_r.is_set_ack;

endmodule

FILE: rtl/srfc_checker.sv
// Port-level assertions for the frame checker and their bind to the top level.
`include "sensor_response_frame_checker_unit_defines.svh"

module srfc_checker
  import srfc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_frame_end,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [7:0]  out_command,
  input logic [15:0] out_co2_ppm,
  input logic [7:0]  out_abc_enable,
  input logic [7:0]  out_abc_period,
  input logic [15:0] out_abc_base_ppm,
  input logic [15:0] out_meas_period,
  input logic [7:0]  out_smooth_count,
  input logic [7:0]  out_work_mode,
  input logic        out_is_set_ack
);

  logic stalled;
  logic fields_zero;

  assign stalled     = out_valid && !out_ready;
  assign fields_zero = (out_co2_ppm == '0) && (out_abc_enable == '0) &&
                       (out_abc_period == '0) && (out_abc_base_ppm == '0) &&
                       (out_meas_period == '0) && (out_smooth_count == '0) &&
                       (out_work_mode == '0) && !out_is_set_ack;

  `SRFC_ASSERT_NXT(a_hold_valid, clk, rst_n, stalled, out_valid)
  `SRFC_ASSERT_NXT(a_hold_word, clk, rst_n, stalled, $stable(out_status) && $stable(out_command))
  `SRFC_ASSERT_IMP(a_new_word_src, clk, rst_n, out_valid && !$past(stalled), $past(in_valid && in_ready && in_frame_end))
  `SRFC_ASSERT_IMP(a_fail_zero, clk, rst_n, out_valid && (out_status != ST_OK), fields_zero)
  `SRFC_ASSERT_IMP(a_ack_cmd, clk, rst_n, out_valid && out_is_set_ack, (out_command == CMD_MEAS_CFG) || (out_command == CMD_WORK_MODE))

endmodule

bind sensor_response_frame_checker_unit srfc_checker u_srfc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_frame_end     (in_ch.frame_end),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_command      (out_ch.command),
  .out_co2_ppm      (out_ch.co2_ppm),
  .out_abc_enable   (out_ch.abc_enable),
  .out_abc_period   (out_ch.abc_period),
  .out_abc_base_ppm (out_ch.abc_base_ppm),
  .out_meas_period  (out_ch.meas_period),
  .out_smooth_count (out_ch.smooth_count),
  .out_work_mode    (out_ch.work_mode),
  .out_is_set_ack   (out_ch.is_set_ack)
);

FILE: tb/sensor_response_frame_checker_unit_tb.sv
// Self-checking testbench for the frame checker: directed frames, then random frames with gaps.
module sensor_response_frame_checker_unit_tb
  import srfc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 4000;
  localparam int TARGET_WORDS = 1800;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [7:0] b;
    logic       last;
    bit         typed;
    result_t    want;
  } frame_row_t;

  logic clk = 1'b0;
  logic rst_n;

  srfc_in_if  in_ch();
  srfc_out_if out_ch();

  sensor_response_frame_checker_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // frame tracking state
  logic [CNT_W-1:0] frame_len = '0;
  logic [7:0]       frame_sum = '0;
  logic [7:0]       frame_head [HEAD_BYTES] = '{default: '0};

  result_t    expected_words [$];
  int         error_count = 0;
  int         words_sent = 0;
  int         results_seen = 0;
  int         idle_cycles = 0;
  bit         sender_burst = 1'b0;
  bit         held_off = 1'b0;
  frame_row_t frame_rows [20];
  logic [7:0] known_cmds [9] = '{CMD_READ_CO2, CMD_ZERO_CAL, CMD_ABC, CMD_SET_ABC,
                                 CMD_SPAN_CAL, CMD_VERSION, CMD_SERIAL, CMD_MEAS_CFG,
                                 CMD_WORK_MODE};

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic result_t rejected_word(status_t st, logic [7:0] cmd, logic known);
    result_t w;
    w = '0;
    w.status = st;
    w.command = cmd;
    w.known_command = known;
    return w;
  endfunction

  // Updates the frame state with one byte; on the last byte yields the decoded result.
  task automatic frame_track(input logic [7:0] b, input logic last, output bit done,
                             output result_t word);
    logic [7:0] cmd;
    status_t    st;
    word = '0;
    done = 1'b0;
    if (frame_len < HEAD_BYTES) frame_head[frame_len[HEAD_IDX_W-1:0]] = b;
    if (frame_len != COUNT_MAX) frame_len = frame_len + 1'b1;
    frame_sum = frame_sum + b;
    if (!last) return;
    if (frame_len < MIN_BYTES) st = ST_SHORT;
    else if (frame_head[0] != HEADER_CODE) st = ST_BAD_HEADER;
    else if (frame_sum != 8'h00) st = ST_BAD_SUM;
    else st = ST_OK;
    cmd = frame_head[2];
    word.status = st;
    word.command = cmd;
    case (cmd)
      CMD_READ_CO2, CMD_ZERO_CAL, CMD_ABC, CMD_SET_ABC, CMD_SPAN_CAL, CMD_VERSION,
      CMD_SERIAL, CMD_MEAS_CFG, CMD_WORK_MODE: word.known_command = 1'b1;
      default: word.known_command = 1'b0;
    endcase
    if (st == ST_OK) begin
      case (cmd)
        CMD_READ_CO2: word.co2_ppm = {frame_head[3], frame_head[4]};
        CMD_ABC: begin
          word.abc_enable = frame_head[4];
          word.abc_period = frame_head[5];
          word.abc_base_ppm = {frame_head[6], frame_head[7]};
        end
        CMD_MEAS_CFG: begin
          if (frame_head[1] <= ACK_MAX_LEN) begin
            word.is_set_ack = 1'b1;
          end else begin
            word.meas_period = {frame_head[3], frame_head[4]};
            word.smooth_count = frame_head[5];
          end
        end
        CMD_WORK_MODE: begin
          if (frame_head[1] <= ACK_MAX_LEN) word.is_set_ack = 1'b1;
          else word.work_mode = frame_head[3];
        end
        default: ;
      endcase
    end
    frame_len = '0;
    frame_sum = '0;
    frame_head = '{default: '0};
    done = 1'b1;
  endtask

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic push_word(input logic [7:0] b, input logic last, input bit typed,
                           input result_t want);
    int      gap;
    bit      done;
    result_t word;
    gap = sender_burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.rx_byte = b;
    in_ch.frame_end = last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    words_sent++;
    frame_track(b, last, done, word);
    if (done) expected_words.push_back(typed ? want : word);
    @(negedge clk);
  endtask

  task automatic send_random_frame();
    logic [7:0] fb [$];
    logic [7:0] sum;
    int         kind;
    int         n;
    kind = $urandom_range(0, 99);
    sender_burst = ($urandom_range(0, 3) == 0);
    if (kind < 88) begin
      fb.push_back(HEADER_CODE);
      fb.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 4)) : 8'($urandom));
      fb.push_back(($urandom_range(0, 4) != 0) ? known_cmds[$urandom_range(0, 8)]
                                                : 8'($urandom));
      n = $urandom_range(0, 99);
      n = (n < 90) ? $urandom_range(0, 8) : (n < 97) ? $urandom_range(9, 20)
                                                    : $urandom_range(60, 70);
      repeat (n) fb.push_back(8'($urandom));
      sum = 8'h00;
      foreach (fb[i]) sum = sum + fb[i];
      fb.push_back(8'(8'h00 - sum));
      if (kind >= 70 && kind < 80) begin
        fb[fb.size()-1] = fb[fb.size()-1] + 8'($urandom_range(1, 255));
      end else if (kind >= 80) begin
        fb[0] = 8'($urandom);
        if (fb[0] == HEADER_CODE) fb[0] = fb[0] ^ 8'h01;
      end
    end else if (kind < 94) begin
      repeat ($urandom_range(1, 2)) fb.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 12)) fb.push_back(8'($urandom));
    end
    foreach (fb[i]) push_word(fb[i], (i == fb.size() - 1), 1'b0, '0);
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // result word checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      results_seen++;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word: expected none, got status %0h command %0h",
                 $time, out_ch.status, out_ch.command);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        check_field("status", want.status, out_ch.status);
        check_field("command", want.command, out_ch.command);
        check_field("known_command", want.known_command, out_ch.known_command);
        check_field("co2_ppm", want.co2_ppm, out_ch.co2_ppm);
        check_field("abc_enable", want.abc_enable, out_ch.abc_enable);
        check_field("abc_period", want.abc_period, out_ch.abc_period);
        check_field("abc_base_ppm", want.abc_base_ppm, out_ch.abc_base_ppm);
        check_field("meas_period", want.meas_period, out_ch.meas_period);
        check_field("smooth_count", want.smooth_count, out_ch.smooth_count);
        check_field("work_mode", want.work_mode, out_ch.work_mode);
        check_field("is_set_ack", want.is_set_ack, out_ch.is_set_ack);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results still expected",
               $time, idle_cycles, expected_words.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result sink: random stalls, one long hold-off to back up the input
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (!held_off && results_seen >= 40) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        held_off = 1'b1;
      end
      out_ch.ready = 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.rx_byte = 8'h00;
    in_ch.frame_end = 1'b0;
    rst_n = 1'b0;

    frame_rows = '{
      '{8'h00, 1'b1, 1'b1, rejected_word(ST_SHORT, 8'h00, 1'b0)},
      '{HEADER_CODE, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b1, 1'b1, rejected_word(ST_SHORT, 8'h00, 1'b0)},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b1, 1'b1, rejected_word(ST_BAD_HEADER, 8'hFF, 1'b0)},
      '{HEADER_CODE, 1'b0, 1'b0, '0},
      '{8'h05, 1'b0, 1'b0, '0},
      '{CMD_READ_CO2, 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b1, rejected_word(ST_BAD_SUM, CMD_READ_CO2, 1'b1)},
      '{HEADER_CODE, 1'b0, 1'b0, '0},
      '{8'h05, 1'b0, 1'b0, '0},
      '{CMD_READ_CO2, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hE6, 1'b1, 1'b0, '0},
      '{HEADER_CODE, 1'b0, 1'b0, '0},
      '{8'h01, 1'b0, 1'b0, '0},
      '{CMD_WORK_MODE, 1'b0, 1'b0, '0},
      '{8'h98, 1'b1, 1'b0, '0}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (frame_rows[i]) begin
      push_word(frame_rows[i].b, frame_rows[i].last, frame_rows[i].typed, frame_rows[i].want);
    end
    while (words_sent < TARGET_WORDS) send_random_frame();
    in_ch.valid = 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
